@@ sv/totp_pkg.sv @@
// shared types, constants and helpers for the one-time code block
// no dependencies
`timescale 1ns / 1ps

package totp_pkg;

  // key storage, verify window and digit count limits
  localparam int KEY_BYTES = 32;
  localparam logic [5:0] KEY_BYTES_W = 6'(KEY_BYTES);
  localparam logic [3:0] MAX_WINDOW = 4'd15;
  localparam logic [3:0] MAX_DIGITS = 4'd9;

  // commands
  localparam logic [1:0] CMD_HOTP   = 2'd0;
  localparam logic [1:0] CMD_TOTP   = 2'd1;
  localparam logic [1:0] CMD_VERIFY = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_KLEN   = 3'd4;
  localparam logic [2:0] REG_DIGITS = 3'd5;
  localparam logic [2:0] REG_TSTEP  = 3'd6;
  localparam logic [2:0] REG_SYNC   = 3'd7;

  // sha-1 initial hash and round constants
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] RK0 = 32'h5A827999;
  localparam logic [31:0] RK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RK3 = 32'hCA62C1D6;

  // hmac pads and padding words
  localparam logic [31:0] IPAD = 32'h36363636;
  localparam logic [31:0] OPAD = 32'h5C5C5C5C;
  localparam logic [31:0] PAD_ONE = 32'h80000000;
  localparam logic [31:0] INNER_BITS = 32'd576;
  localparam logic [31:0] OUTER_BITS = 32'd672;

  // block numbers within one hmac
  localparam logic [1:0] BLK_IKEY = 2'd0;
  localparam logic [1:0] BLK_IMSG = 2'd1;
  localparam logic [1:0] BLK_OKEY = 2'd2;
  localparam logic [1:0] BLK_OMSG = 2'd3;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] LAST_DIV   = 7'd62;
  localparam logic [6:0] LAST_MOD   = 7'd30;

  // which counter goes into the hmac
  typedef enum logic [1:0] {
    CTR_BASE  = 2'd0,
    CTR_MINUS = 2'd1,
    CTR_PLUS  = 2'd2
  } ctr_sel_t;

  typedef struct packed {
    logic [255:0] key;
    logic [5:0]   key_len;
    logic [3:0]   digits;
    logic [15:0]  time_step;
    logic [3:0]   sync_window;
  } cfg_t;

  typedef struct packed {
    logic       latch;
    logic       div_step;
    logic       ctr_load;
    ctr_sel_t   ctr_sel;
    logic [3:0] k;
    logic       blk_load;
    logic [1:0] blk;
    logic       rnd;
    logic [6:0] round;
    logic       fin;
    logic       mod_init;
    logic       mod_step;
    logic       code_save;
    logic       hit_test;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       step_ge_k;
    logic       hit_now;
  } dp_stat_t;

  // modulus for a digit count, clamped
  function automatic logic [29:0] pow_ten(input logic [3:0] d);
    logic [29:0] r;
    case (d)
      4'd0: r = 30'd1;
      4'd1: r = 30'd10;
      4'd2: r = 30'd100;
      4'd3: r = 30'd1000;
      4'd4: r = 30'd10000;
      4'd5: r = 30'd100000;
      4'd6: r = 30'd1000000;
      4'd7: r = 30'd10000000;
      4'd8: r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

@@ sv/totp_cfg.sv @@
// configuration register file for the one-time code block
// depends on totp_pkg
`timescale 1ns / 1ps

module totp_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  output totp_pkg::cfg_t      cfg
);
  import totp_pkg::*;

  logic [63:0] key_word [4];
  logic [5:0]  key_len;
  logic [3:0]  digits;
  logic [15:0] time_step;
  logic [3:0]  sync_window;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word[0] <= '0;
      key_word[1] <= '0;
      key_word[2] <= '0;
      key_word[3] <= '0;
      key_len     <= 6'd20;
      digits      <= 4'd6;
      time_step   <= 16'd30;
      sync_window <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:   key_word[0] <= cfg_wdata;
        REG_KEY1:   key_word[1] <= cfg_wdata;
        REG_KEY2:   key_word[2] <= cfg_wdata;
        REG_KEY3:   key_word[3] <= cfg_wdata;
        REG_KLEN:   key_len     <= cfg_wdata[5:0];
        REG_DIGITS: digits      <= cfg_wdata[3:0];
        REG_TSTEP:  time_step   <= cfg_wdata[15:0];
        REG_SYNC:   sync_window <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign cfg.key         = {key_word[0], key_word[1], key_word[2], key_word[3]};
  assign cfg.key_len     = key_len;
  assign cfg.digits      = digits;
  assign cfg.time_step   = time_step;
  assign cfg.sync_window = sync_window;

endmodule

@@ sv/totp_dp.sv @@
// datapath: step divider, sha-1 round unit, truncation and decimal reduction
// depends on totp_pkg
`timescale 1ns / 1ps

module totp_dp (
  input  logic                clk,
  input  logic                rst,
  input  totp_pkg::cfg_t      cfg,
  input  totp_pkg::dp_cmd_t   dcmd,
  input  logic [1:0]          cmd,
  input  logic [62:0]         value,
  input  logic [29:0]         token,
  output totp_pkg::dp_stat_t  stat,
  output logic [29:0]         code,
  output logic                match
);
  import totp_pkg::*;

  logic [1:0]  cmd_r;
  logic [29:0] token_r;
  logic [62:0] q;
  logic [15:0] drem;
  logic [63:0] ctr;
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic [31:0] ih [5];
  logic [31:0] win [16];
  logic [30:0] mv;
  logic [30:0] mrem;
  logic [29:0] code_r;
  logic        hit;

  // clamped configuration
  logic [15:0] ts;
  logic [5:0]  klen;
  logic [3:0]  dg;
  logic [29:0] modulus;
  assign ts      = (cfg.time_step == 16'd0) ? 16'd1 : cfg.time_step;
  assign klen    = (cfg.key_len > KEY_BYTES_W) ? KEY_BYTES_W : cfg.key_len;
  assign dg      = (cfg.digits > MAX_DIGITS) ? MAX_DIGITS : cfg.digits;
  assign modulus = pow_ten(dg);

  // key bytes past the key length read as zero
  logic [255:0] kmask;
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      kmask[255 - 8 * i -: 8] = (6'(i) < klen) ? cfg.key[255 - 8 * i -: 8] : 8'h00;
    end
  end

  // message words of the block being loaded
  logic [31:0] blkw [16];
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      blkw[j] = '0;
    end
    case (dcmd.blk)
      BLK_IKEY: begin
        for (int j = 0; j < 16; j++) begin
          blkw[j] = (j < 8) ? (kmask[255 - 32 * j -: 32] ^ IPAD) : IPAD;
        end
      end
      BLK_IMSG: begin
        blkw[0]  = ctr[63:32];
        blkw[1]  = ctr[31:0];
        blkw[2]  = PAD_ONE;
        blkw[15] = INNER_BITS;
      end
      BLK_OKEY: begin
        for (int j = 0; j < 16; j++) begin
          blkw[j] = (j < 8) ? (kmask[255 - 32 * j -: 32] ^ OPAD) : OPAD;
        end
      end
      BLK_OMSG: begin
        for (int j = 0; j < 5; j++) begin
          blkw[j] = ih[j];
        end
        blkw[5]  = PAD_ONE;
        blkw[15] = OUTER_BITS;
      end
      default: ;
    endcase
  end

  // round function
  logic [31:0] f, kc, temp, wnew;
  always_comb begin
    if (dcmd.round < 7'd20) begin
      f  = (b & c) | (~b & d);
      kc = RK0;
    end else if (dcmd.round < 7'd40) begin
      f  = b ^ c ^ d;
      kc = RK1;
    end else if (dcmd.round < 7'd60) begin
      f  = (b & c) | (b & d) | (c & d);
      kc = RK2;
    end else begin
      f  = b ^ c ^ d;
      kc = RK3;
    end
    temp = {a[26:0], a[31:27]} + f + e + kc + win[0];
    wnew = win[13] ^ win[8] ^ win[2] ^ win[0];
  end

  // dynamic truncation of the mac
  logic [159:0] mac, mac_sh;
  assign mac    = {h[0], h[1], h[2], h[3], h[4]};
  assign mac_sh = mac << {h[4][3:0], 3'b000};

  // divider and reduction steps
  logic [16:0] dsh;
  logic        dge;
  logic [30:0] msh;
  logic        mge;
  assign dsh = {drem, q[62]};
  assign dge = dsh >= {1'b0, ts};
  assign msh = {mrem[29:0], mv[30]};
  assign mge = msh >= {1'b0, modulus};

  logic hit_now;
  assign hit_now = (mrem == {1'b0, token_r});

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_r  <= '0;
      hit    <= 1'b0;
      code_r <= '0;
    end else if (dcmd.latch) begin
      cmd_r  <= cmd;
      hit    <= 1'b0;
      code_r <= '0;
    end else begin
      if (dcmd.code_save) code_r <= mrem[29:0];
      if (dcmd.hit_test)  hit    <= hit | hit_now;
    end
  end

  // divider
  always_ff @(posedge clk) begin
    if (dcmd.latch) begin
      token_r <= token;
      q       <= value;
      drem    <= '0;
    end else if (dcmd.div_step) begin
      drem <= dge ? 16'(dsh - {1'b0, ts}) : dsh[15:0];
      q    <= {q[61:0], dge};
    end
  end

  // hmac counter
  always_ff @(posedge clk) begin
    if (dcmd.ctr_load) begin
      case (dcmd.ctr_sel)
        CTR_MINUS: ctr <= {1'b0, q} - 64'(dcmd.k);
        CTR_PLUS:  ctr <= {1'b0, q} + 64'(dcmd.k);
        default:   ctr <= {1'b0, q};
      endcase
    end
  end

  // compression state
  always_ff @(posedge clk) begin
    if (dcmd.blk_load) begin
      for (int j = 0; j < 16; j++) begin
        win[j] <= blkw[j];
      end
      if (dcmd.blk == BLK_IKEY || dcmd.blk == BLK_OKEY) begin
        h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
        a <= IV0; b <= IV1; c <= IV2; d <= IV3; e <= IV4;
      end else begin
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
      end
      if (dcmd.blk == BLK_OKEY) begin
        for (int j = 0; j < 5; j++) begin
          ih[j] <= h[j];
        end
      end
    end else if (dcmd.rnd) begin
      for (int j = 0; j < 15; j++) begin
        win[j] <= win[j + 1];
      end
      win[15] <= {wnew[30:0], wnew[31]};
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= temp;
    end else if (dcmd.fin) begin
      h[0] <= h[0] + a;
      h[1] <= h[1] + b;
      h[2] <= h[2] + c;
      h[3] <= h[3] + d;
      h[4] <= h[4] + e;
    end
  end

  // decimal reduction
  always_ff @(posedge clk) begin
    if (dcmd.mod_init) begin
      mv   <= mac_sh[158:128];
      mrem <= '0;
    end else if (dcmd.mod_step) begin
      mrem <= mge ? (msh - {1'b0, modulus}) : msh;
      mv   <= {mv[29:0], 1'b0};
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.step_ge_k = {1'b0, q} >= 64'(dcmd.k);
  assign stat.hit_now   = hit_now;
  assign code  = code_r;
  assign match = hit;

  // a match can only come out of a verify command
  a_match_verify: assert property (@(posedge clk) disable iff (rst)
    match |-> (cmd_r == CMD_VERIFY))
    else $error("match set outside verify");

endmodule

@@ sv/totp_ctrl.sv @@
// controller: sequences division, four compressions, reduction and window scan
// depends on totp_pkg
`timescale 1ns / 1ps

module totp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          cmd,
  input  totp_pkg::cfg_t      cfg,
  input  totp_pkg::dp_stat_t  stat,
  output totp_pkg::dp_cmd_t   dcmd,
  output logic                busy,
  output logic                done
);
  import totp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DIV   = 11'b00000000010,
    S_SETUP = 11'b00000000100,
    S_LOAD  = 11'b00000001000,
    S_ROUND = 11'b00000010000,
    S_FIN   = 11'b00000100000,
    S_TRUNC = 11'b00001000000,
    S_MOD   = 11'b00010000000,
    S_EVAL  = 11'b00100000000,
    S_NEXT  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t     state, state_next;
  logic [6:0] cnt, cnt_next;
  logic [1:0] blk, blk_next;
  logic [3:0] k, k_next;
  ctr_sel_t   phase, phase_next;
  logic [3:0] wmax;

  assign wmax = (cfg.sync_window > MAX_WINDOW) ? MAX_WINDOW : cfg.sync_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      blk   <= '0;
      k     <= '0;
      phase <= CTR_BASE;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      blk   <= blk_next;
      k     <= k_next;
      phase <= phase_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    blk_next   = blk;
    k_next     = k;
    phase_next = phase;
    dcmd       = '0;
    dcmd.ctr_sel = phase;
    dcmd.k     = k;
    dcmd.blk   = blk;
    dcmd.round = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          dcmd.latch = 1'b1;
          phase_next = CTR_BASE;
          k_next     = '0;
          cnt_next   = '0;
          if (cmd == CMD_HOTP) state_next = S_SETUP;
          else if (cmd == CMD_TOTP || cmd == CMD_VERIFY) state_next = S_DIV;
          else state_next = S_DONE;
        end
      end
      S_DIV: begin
        dcmd.div_step = 1'b1;
        cnt_next = cnt + 7'd1;
        if (cnt == LAST_DIV) state_next = S_SETUP;
      end
      S_SETUP: begin
        dcmd.ctr_load = 1'b1;
        blk_next   = BLK_IKEY;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        dcmd.blk_load = 1'b1;
        cnt_next   = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        dcmd.rnd = 1'b1;
        cnt_next = cnt + 7'd1;
        if (cnt == LAST_ROUND) state_next = S_FIN;
      end
      S_FIN: begin
        dcmd.fin = 1'b1;
        if (blk == BLK_OMSG) begin
          state_next = S_TRUNC;
        end else begin
          blk_next   = blk + 2'd1;
          state_next = S_LOAD;
        end
      end
      S_TRUNC: begin
        dcmd.mod_init = 1'b1;
        cnt_next   = '0;
        state_next = S_MOD;
      end
      S_MOD: begin
        dcmd.mod_step = 1'b1;
        cnt_next = cnt + 7'd1;
        if (cnt == LAST_MOD) state_next = S_EVAL;
      end
      S_EVAL: begin
        case (phase)
          CTR_BASE: begin
            dcmd.code_save = 1'b1;
            if (stat.cmd != CMD_VERIFY) begin
              state_next = S_DONE;
            end else begin
              dcmd.hit_test = 1'b1;
              if (stat.hit_now || wmax == 4'd0) begin
                state_next = S_DONE;
              end else begin
                k_next     = 4'd1;
                state_next = S_NEXT;
              end
            end
          end
          CTR_MINUS: begin
            dcmd.hit_test = 1'b1;
            if (stat.hit_now) begin
              state_next = S_DONE;
            end else begin
              phase_next = CTR_PLUS;
              state_next = S_SETUP;
            end
          end
          default: begin
            dcmd.hit_test = 1'b1;
            if (stat.hit_now || k == wmax) begin
              state_next = S_DONE;
            end else begin
              k_next     = k + 4'd1;
              state_next = S_NEXT;
            end
          end
        endcase
      end
      S_NEXT: begin
        // steps before time zero are skipped
        phase_next = stat.step_ge_k ? CTR_MINUS : CTR_PLUS;
        state_next = S_SETUP;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (cnt <= LAST_ROUND))
    else $error("round counter out of range");

endmodule

@@ sv/totp_generate_verify.sv @@
// top level of the hotp / totp code generator and verifier
// depends on totp_pkg, totp_cfg, totp_ctrl and totp_dp
`timescale 1ns / 1ps

// channel  signals                           handshake
// config   cfg_we, cfg_index, cfg_wdata      write when cfg_we high
// command  start, cmd, value, token          taken when start and not busy
// result   done, code, match                 one beat while done high
//
// one command at a time; an hmac is four sha-1 compressions on one shared round
// unit, plus truncation and the bit-serial decimal reduction; totp and verify
// commands add the bit-serial time-step division. verify costs one hmac per
// tested step, up to 1 + 2 * sync_window of them. reset is synchronous and
// restores the register defaults; the result beat cannot be held off by the
// receiver.

module totp_generate_verify (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [62:0] value,
  input  logic [29:0] token,
  output logic        done,
  output logic [29:0] code,
  output logic        match
);
  import totp_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dcmd;
  dp_stat_t stat;

  totp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  totp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .cfg   (cfg),
    .stat  (stat),
    .dcmd  (dcmd),
    .busy  (busy),
    .done  (done)
  );

  totp_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .dcmd  (dcmd),
    .cmd   (cmd),
    .value (value),
    .token (token),
    .stat  (stat),
    .code  (code),
    .match (match)
  );

endmodule

@@ sim/tb_totp_generate_verify.sv @@
// self-checking testbench for the hotp / totp code generator and verifier
// depends on totp_pkg and totp_generate_verify; holds its own hmac-sha1 predictor
`timescale 1ns / 1ps

module tb_totp_generate_verify;
  import totp_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = '0;
  logic [62:0] value = '0;
  logic [29:0] token = '0;
  logic        done;
  logic [29:0] code;
  logic        match;

  // predictor copy of the configuration registers
  logic [63:0] key_reg [4];
  logic [5:0]  klen_reg;
  logic [3:0]  digits_reg;
  logic [15:0] tstep_reg;
  logic [3:0]  sync_reg;

  int n_hotp, n_totp, n_verify, n_hits, n_beats;
  int idle_cycles;

  always #2 clk = ~clk;

  totp_generate_verify u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .cmd(cmd), .value(value), .token(token),
    .done(done), .code(code), .match(match)
  );

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one sha-1 compression of a 512-bit block, first word in the top bits
  function automatic logic [159:0] sha1_compress(input logic [159:0] h,
                                                 input logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = RK0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = RK1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = RK2;
      end else begin
        f = b ^ c ^ d; k = RK3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  // hotp code of a counter under the current key, length and digit count
  function automatic logic [29:0] hotp_of(input logic [63:0] counter);
    logic [255:0] kb;
    logic [159:0] h, mac;
    logic [31:0]  v;
    logic [31:0]  modulus;
    int len, dg, off;
    len = (klen_reg > 6'd32) ? 32 : int'(klen_reg);
    dg = (digits_reg > 4'd9) ? 9 : int'(digits_reg);
    kb = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
    for (int i = 0; i < 32; i++) if (i >= len) kb[255 - 8 * i -: 8] = 8'h00;
    // inner hash: key xor ipad, then counter and padding for 72 bytes
    h = sha1_compress({IV0, IV1, IV2, IV3, IV4}, {kb, 256'b0} ^ {16{IPAD}});
    h = sha1_compress(h, {counter, PAD_ONE, 384'b0, INNER_BITS});
    // outer hash: key xor opad, then inner digest and padding for 84 bytes
    mac = sha1_compress({IV0, IV1, IV2, IV3, IV4}, {kb, 256'b0} ^ {16{OPAD}});
    mac = sha1_compress(mac, {h, PAD_ONE, 288'b0, OUTER_BITS});
    // dynamic truncation
    off = int'(mac[3:0]);
    v = mac[159 - 8 * off -: 32] & 32'h7FFFFFFF;
    modulus = 1;
    for (int i = 0; i < dg; i++) modulus = modulus * 10;
    return 30'(v % modulus);
  endfunction

  function automatic logic [63:0] step_of(input logic [62:0] t);
    logic [63:0] ts;
    ts = (tstep_reg == 16'd0) ? 64'd1 : 64'(tstep_reg);
    return 64'(t) / ts;
  endfunction

  typedef struct packed {
    logic [29:0] code;
    logic        match;
  } code_beat_t;

  class code_scoreboard;
    code_beat_t pending[$];
    int errors;

    // predict the result of an accepted command beat
    function void note_command(logic [1:0] c, logic [62:0] v, logic [29:0] tok);
      code_beat_t e;
      logic [63:0] st;
      int win;
      e = '0;
      win = (sync_reg > MAX_WINDOW) ? int'(MAX_WINDOW) : int'(sync_reg);
      if (c == CMD_HOTP) begin
        e.code = hotp_of(64'(v));
      end else if (c == CMD_TOTP) begin
        e.code = hotp_of(step_of(v));
      end else if (c == CMD_VERIFY) begin
        st = step_of(v);
        e.code = hotp_of(st);
        e.match = (e.code == tok);
        for (int k = 1; k <= win && !e.match; k++) begin
          // steps before time zero are skipped
          if (st >= 64'(k) && hotp_of(st - 64'(k)) == tok) e.match = 1'b1;
          else if (hotp_of(st + 64'(k)) == tok) e.match = 1'b1;
        end
        if (e.match) n_hits++;
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [29:0] c, logic m);
      code_beat_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat code=%0d match=%0b", $time, c, m);
        return;
      end
      e = pending.pop_front();
      if (c !== e.code) begin
        errors++;
        $display("%0t: code mismatch expected %0d actual %0d", $time, e.code, c);
      end
      if (m !== e.match) begin
        errors++;
        $display("%0t: match mismatch expected %0b actual %0b", $time, e.match, m);
      end
    endfunction
  endclass

  code_scoreboard sb = new();

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(code, match);
      n_beats++;
    end
  end

  // watchdog on cycles with no accepted command and no result beat
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // write enable stays high across consecutive writes
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write every register and mirror it in the predictor
  task automatic load_config(input logic [255:0] key, input logic [5:0] klen,
                             input logic [3:0] dg, input logic [15:0] ts,
                             input logic [3:0] sw);
    drain();
    @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      key_reg[i] = key[255 - 64 * i -: 64];
      write_reg(REG_KEY0 + 3'(i), key_reg[i]);
    end
    write_reg(REG_KLEN, 64'(klen));
    write_reg(REG_DIGITS, 64'(dg));
    write_reg(REG_TSTEP, 64'(ts));
    write_reg(REG_SYNC, 64'(sw));
    cfg_we <= 1'b0;
    klen_reg = klen; digits_reg = dg; tstep_reg = ts; sync_reg = sw;
  endtask

  // one command beat; start stays high across back-to-back beats
  task automatic send(input logic [1:0] c, input logic [62:0] v, input logic [29:0] tok);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    value <= v;
    token <= tok;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c, v, tok);
    if (c == CMD_HOTP) n_hotp++;
    else if (c == CMD_TOTP) n_totp++;
    else if (c == CMD_VERIFY) n_verify++;
  endtask

  function automatic logic [62:0] rand_value();
    logic [62:0] v;
    case ($urandom_range(0, 3))
      0: v = 63'($urandom_range(0, 100));
      1: v = 63'({$urandom(), $urandom()});
      2: v = 63'h7FFF_FFFF_FFFF_FFFF - 63'($urandom_range(0, 100));
      default: v = 63'(64'd1700000000 + 64'($urandom_range(0, 1 << 24)));
    endcase
    return v;
  endfunction

  // verify token: mostly a real code near the current step, otherwise noise
  function automatic logic [29:0] pick_token(input logic [62:0] v);
    logic [63:0] st;
    int win, off;
    win = int'(sync_reg);
    st = step_of(v);
    off = int'($urandom_range(0, 2 * win + 2)) - (win + 1);
    if ($urandom_range(0, 2) == 0 || (off < 0 && st < 64'(-off)))
      return 30'($urandom());
    return hotp_of(st + 64'(off));
  endfunction

  task automatic random_items(input int n);
    logic [1:0]  c;
    logic [62:0] v;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      v = rand_value();
      // one pause until every outstanding code has come back
      if (i == n / 2) begin
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send(c, v, (c == CMD_VERIFY) ? pick_token(v) : 30'($urandom()));
    end
  endtask

  function automatic logic [255:0] rand_key();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  initial begin
    key_reg[0] = '0; key_reg[1] = '0; key_reg[2] = '0; key_reg[3] = '0;
    klen_reg = 6'd20; digits_reg = 4'd6; tstep_reg = 16'd30; sync_reg = 4'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, field extremes, window before time zero
    send(CMD_HOTP, '0, '0);
    send(CMD_HOTP, '1, '1);
    send(CMD_TOTP, '0, '0);
    send(CMD_TOTP, 63'd59, '0);
    send(CMD_TOTP, '1, '1);
    send(CMD_VERIFY, 63'd5, hotp_of(64'd1));
    send(CMD_VERIFY, 63'd75, hotp_of(64'd1));
    send(CMD_VERIFY, 63'd75, hotp_of(64'd3));
    send(CMD_VERIFY, 63'd75, '1);
    send(CMD_VERIFY, '1, '0);
    send(2'd3, '1, '1);
    send(2'd3, '0, '0);

    // published test key, eight digits
    load_config({"12345678901234567890", 96'b0}, 6'd20, 4'd8, 16'd30, 4'd1);
    send(CMD_TOTP, 63'd59, '0);
    send(CMD_TOTP, 63'd1111111109, '0);
    send(CMD_HOTP, 63'd1, '0);
    send(CMD_VERIFY, 63'd59, hotp_of(64'd2));

    // long key length clamps, too many digits clamp, zero time step
    load_config('1, 6'd63, 4'd15, 16'd0, 4'd3);
    send(CMD_TOTP, 63'd7, '0);
    send(CMD_VERIFY, 63'd1, hotp_of(64'd4));
    send(CMD_VERIFY, 63'd2, hotp_of(64'd0));
    random_items(150);

    // zero digits, empty key, widest step and window
    load_config(rand_key(), 6'd0, 4'd0, 16'hFFFF, 4'd15);
    send(CMD_VERIFY, 63'd0, 30'd0);
    send(CMD_VERIFY, 63'd0, 30'd1);
    random_items(12);

    // full-length key, nine digits, step of one, no window
    load_config(rand_key(), 6'd32, 4'd9, 16'd1, 4'd0);
    random_items(250);

    // random settings with small windows
    for (int p = 0; p < 6; p++) begin
      load_config(rand_key(), 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                  16'($urandom()), 4'($urandom_range(0, 3)));
      random_items(180);
    end

    // one more random wide window, few beats
    load_config(rand_key(), 6'($urandom_range(1, 32)), 4'($urandom_range(1, 9)),
                16'($urandom_range(1, 300)), 4'($urandom_range(8, 15)));
    random_items(10);

    @(posedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d hotp, %0d totp and %0d verify commands, %0d verify hits",
             n_hotp, n_totp, n_verify, n_hits);
    $display("%0d result beats checked over twelve register settings", n_beats);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
